### design/cpv_pkg.sv
package cpv_pkg;

    // field widths
    localparam int unsigned DAY_W    = 20;
    localparam int unsigned SEC_W    = 17;
    localparam int unsigned NANO_W   = 30;
    localparam int unsigned ENERGY_W = 16;
    localparam int unsigned POS_W    = 15;
    localparam int unsigned SQ_W     = 29;
    localparam int unsigned R2_W     = 30;
    localparam int unsigned COUNT_W  = 32;

    // stream packing
    localparam int unsigned S_TDATA_W = 128;
    localparam int unsigned M_TDATA_W = 80;
    localparam int unsigned M_TUSER_W = 3;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 30;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_ENERGY = 1'b0,
        CFG_WINDOW     = 1'b1
    } cfg_index_t;

    // region of interest: energy window in keV and squared radius in mm^2
    localparam logic [ENERGY_W-1:0] ROI_E_LOW    = 16'd2470;
    localparam logic [ENERGY_W-1:0] ROI_E_HIGH   = 16'd2640;
    localparam logic [R2_W-1:0]     ROI_R2_LIMIT = 30'd12250000;

    // positions on m_tuser
    localparam int unsigned MU_KEEP = 0;
    localparam int unsigned MU_ROI  = 1;
    localparam int unsigned MU_LAST = 2;

    // event held in the input register
    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [SEC_W-1:0]    sec;
        logic [NANO_W-1:0]   nano;
        logic [ENERGY_W-1:0] energy;
        logic                fit_ok;
        logic [SQ_W-1:0]     sq_x;
        logic [SQ_W-1:0]     sq_y;
        logic [SQ_W-1:0]     sq_z;
        logic                final_event;
    } event_t;

endpackage

### design/coincidence_pair_veto_core.sv
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tdata event fields, s_tuser fit_ok, s_tlast final_event
// m_      | out | m_tvalid/m_tready  | m_tdata energy and counters, m_tuser flags, m_tlast run_end
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// one input register (squares of the position taken on entry) and one result register;
// a new beat is accepted every cycle while the result register drains, except while a
// final event that follows a held event waits to issue its own result; a beat passes
// the input register, then the result register; the decision for an event appears when
// the next event of the run arrives. a final event that follows a held event yields two
// result beats, issued one after the other through the single result register.
// aresetn is synchronous, active low; it clears control state, counters and configuration registers.
module coincidence_pair_veto_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // day[19:0] second[36:20] nano[66:37] energy[82:67] x[97:83] y[112:98] z[127:113]
    input  logic [cpv_pkg::S_TDATA_W-1:0]      s_tdata,
    // fit_ok[0]
    input  logic                               s_tuser,
    input  logic                               s_tlast,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // decided_energy[15:0] roi_total[47:16] roi_kept[79:48]
    output logic [cpv_pkg::M_TDATA_W-1:0]      m_tdata,
    // keep[0] in_roi[1] last[2]
    output logic [cpv_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                               m_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cpv_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cpv_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration registers
    logic [cpv_pkg::ENERGY_W-1:0] min_energy_reg;
    logic [cpv_pkg::NANO_W-1:0]   window_reg;

    // input register
    logic                 ev_valid_reg;
    cpv_pkg::event_t      ev_reg;
    cpv_pkg::event_t      ev_next;
    logic                 phase_reg;

    // held event
    logic                         held_valid_reg;
    logic [cpv_pkg::DAY_W-1:0]    held_day_reg;
    logic [cpv_pkg::SEC_W-1:0]    held_sec_reg;
    logic [cpv_pkg::NANO_W-1:0]   held_nano_reg;
    logic [cpv_pkg::ENERGY_W-1:0] held_energy_reg;
    logic                         held_fit_reg;
    logic                         held_roi_reg;
    logic                         veto_reg;

    // counters
    logic [cpv_pkg::COUNT_W-1:0]  roi_total_reg;
    logic [cpv_pkg::COUNT_W-1:0]  roi_kept_reg;
    logic [cpv_pkg::COUNT_W-1:0]  roi_total_next;
    logic [cpv_pkg::COUNT_W-1:0]  roi_kept_next;

    // result register
    logic                         m_valid_reg;
    logic [cpv_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [cpv_pkg::M_TUSER_W-1:0] m_user_reg;
    logic                         m_last_reg;

    logic signed [cpv_pkg::POS_W-1:0] pos_x;
    logic signed [cpv_pkg::POS_W-1:0] pos_y;
    logic signed [cpv_pkg::POS_W-1:0] pos_z;
    logic signed [2*cpv_pkg::POS_W-1:0] prod_x;
    logic signed [2*cpv_pkg::POS_W-1:0] prod_y;
    logic signed [2*cpv_pkg::POS_W-1:0] prod_z;

    logic [cpv_pkg::R2_W-1:0]     r2;
    logic                         cur_roi;
    logic [cpv_pkg::NANO_W-1:0]   nano_diff;
    logic                         pair;
    logic                         held_keep;
    logic                         emit_held;
    logic                         emit_fin;
    logic                         hold_only;
    logic                         out_free;
    logic                         emit;
    logic                         done;
    logic                         res_keep;
    logic [cpv_pkg::ENERGY_W-1:0] res_energy;
    logic                         res_roi;
    logic                         res_run_end;
    logic                         res_last;
    logic                         s_fire;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_energy_reg <= '0;
            window_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cpv_pkg::cfg_index_t'(cfg_index))
                cpv_pkg::CFG_MIN_ENERGY: min_energy_reg <= cfg_data[cpv_pkg::ENERGY_W-1:0];
                cpv_pkg::CFG_WINDOW:     window_reg     <= cfg_data[cpv_pkg::NANO_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the input beat and square the position on entry
    assign pos_x  = $signed(s_tdata[97:83]);
    assign pos_y  = $signed(s_tdata[112:98]);
    assign pos_z  = $signed(s_tdata[127:113]);
    assign prod_x = pos_x * pos_x;
    assign prod_y = pos_y * pos_y;
    assign prod_z = pos_z * pos_z;

    always_comb begin
        ev_next.day         = s_tdata[19:0];
        ev_next.sec         = s_tdata[36:20];
        ev_next.nano        = s_tdata[66:37];
        ev_next.energy      = s_tdata[82:67];
        ev_next.fit_ok      = s_tuser;
        ev_next.sq_x        = prod_x[cpv_pkg::SQ_W-1:0];
        ev_next.sq_y        = prod_y[cpv_pkg::SQ_W-1:0];
        ev_next.sq_z        = prod_z[cpv_pkg::SQ_W-1:0];
        ev_next.final_event = s_tlast;
    end

    // region of interest of the registered event
    assign r2 = cpv_pkg::R2_W'(ev_reg.sq_x) + cpv_pkg::R2_W'(ev_reg.sq_y)
              + cpv_pkg::R2_W'(ev_reg.sq_z);
    assign cur_roi = (ev_reg.energy > cpv_pkg::ROI_E_LOW) && (ev_reg.energy < cpv_pkg::ROI_E_HIGH)
                   && (r2 < cpv_pkg::ROI_R2_LIMIT) && ev_reg.fit_ok;

    // coincidence test against the held event
    assign nano_diff = (ev_reg.nano > held_nano_reg) ? (ev_reg.nano - held_nano_reg)
                                                     : (held_nano_reg - ev_reg.nano);
    assign pair = (ev_reg.day == held_day_reg) && (ev_reg.sec == held_sec_reg)
                && (nano_diff < window_reg)
                && (held_energy_reg > min_energy_reg) && (ev_reg.energy > min_energy_reg)
                && held_fit_reg && ev_reg.fit_ok;
    assign held_keep = !(veto_reg || pair);

    // what the registered event does this cycle
    assign emit_held = ev_valid_reg && held_valid_reg && !phase_reg;
    assign emit_fin  = ev_valid_reg && !emit_held && ev_reg.final_event;
    assign hold_only = ev_valid_reg && !emit_held && !ev_reg.final_event;
    assign out_free  = !m_valid_reg || m_tready;
    assign emit      = (emit_held || emit_fin) && out_free;
    assign done      = hold_only || (emit_fin && out_free)
                     || (emit_held && out_free && !ev_reg.final_event);

    assign s_tready = !ev_valid_reg || done;
    assign s_fire   = s_tvalid && s_tready;

    // result fields
    always_comb begin
        if (emit_held) begin
            res_keep    = held_keep;
            res_energy  = held_energy_reg;
            res_roi     = held_roi_reg;
            res_run_end = 1'b0;
            res_last    = !ev_reg.final_event;
        end else begin
            res_keep    = 1'b0;
            res_energy  = ev_reg.energy;
            res_roi     = cur_roi;
            res_run_end = 1'b1;
            res_last    = 1'b1;
        end
    end

    // saturating counters, counted as the result is issued
    always_comb begin
        roi_total_next = roi_total_reg;
        roi_kept_next  = roi_kept_reg;
        if (emit && res_roi) begin
            if (roi_total_reg != '1) begin
                roi_total_next = roi_total_reg + 1'b1;
            end
            if (res_keep && (roi_kept_reg != '1)) begin
                roi_kept_next = roi_kept_reg + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_valid_reg   <= 1'b0;
            phase_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            veto_reg       <= 1'b1;
            roi_total_reg  <= '0;
            roi_kept_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            roi_total_reg <= roi_total_next;
            roi_kept_reg  <= roi_kept_next;

            if (s_fire) begin
                ev_valid_reg <= 1'b1;
            end else if (done) begin
                ev_valid_reg <= 1'b0;
            end

            if (emit_held && out_free) begin
                veto_reg <= pair;
                if (ev_reg.final_event) begin
                    phase_reg <= 1'b1;
                end
            end else if (emit_fin && out_free) begin
                veto_reg       <= 1'b1;
                held_valid_reg <= 1'b0;
                phase_reg      <= 1'b0;
            end else if (hold_only) begin
                held_valid_reg <= 1'b1;
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ev_reg <= ev_next;
        end
        if (done && !ev_reg.final_event) begin
            held_day_reg    <= ev_reg.day;
            held_sec_reg    <= ev_reg.sec;
            held_nano_reg   <= ev_reg.nano;
            held_energy_reg <= ev_reg.energy;
            held_fit_reg    <= ev_reg.fit_ok;
            held_roi_reg    <= cur_roi;
        end
        if (emit) begin
            m_data_reg <= {roi_kept_next, roi_total_next, res_energy};
            m_user_reg <= {res_last, res_roi, res_keep};
            m_last_reg <= res_run_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // the last event of a run is never kept
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> !m_user_reg[cpv_pkg::MU_KEEP])
        else $error("run end result marked keep");

    // a first-of-two result never closes the run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_user_reg[cpv_pkg::MU_LAST] |-> !m_last_reg)
        else $error("run end on non-final result of an item");

    // kept count never passes total count
    assert property (@(posedge aclk) disable iff (!aresetn)
        roi_kept_reg <= roi_total_reg)
        else $error("kept roi count exceeds total");

    // second phase only with an event in the input register and one held
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> ev_valid_reg && held_valid_reg && ev_reg.final_event)
        else $error("second phase without a final event pending");

    // closing a run leaves nothing held and the next event vetoed
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fin && out_free |=> veto_reg && !held_valid_reg && !phase_reg)
        else $error("run not closed after final result");
`endif

endmodule

### sim/veto_checker.sv
module veto_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [cpv_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [cpv_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [cpv_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            m_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  cpv_pkg::cfg_index_t             cfg_index,
    input  logic [cpv_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              in_flight,
    output int                              decided
);
    import cpv_pkg::*;

    // one keep decision as it should leave the block
    typedef struct packed {
        logic                keep;
        logic [ENERGY_W-1:0] energy;
        logic                in_roi;
        logic [COUNT_W-1:0]  roi_total;
        logic [COUNT_W-1:0]  roi_kept;
        logic                run_end;
        logic                is_last;
    } decision_t;

    // register copies
    logic [ENERGY_W-1:0] min_energy;
    logic [NANO_W-1:0]   window;

    // event held back until its neighbor arrives
    logic                held;
    logic [DAY_W-1:0]    held_day;
    logic [SEC_W-1:0]    held_sec;
    logic [NANO_W-1:0]   held_nano;
    logic [ENERGY_W-1:0] held_energy;
    logic                held_fit;
    logic                held_roi;
    logic                veto_next;

    // saturating region-of-interest tallies
    logic [COUNT_W-1:0]  roi_seen;
    logic [COUNT_W-1:0]  roi_passed;

    decision_t owed_q[$];

    // bump the tallies and queue the decision
    task automatic owe_decision(input logic keep, input logic [ENERGY_W-1:0] energy,
                                input logic roi, input logic run_end, input logic is_last);
        decision_t d;
        if (roi) begin
            if (roi_seen != '1) roi_seen++;
            if (keep && roi_passed != '1) roi_passed++;
        end
        d.keep      = keep;
        d.energy    = energy;
        d.in_roi    = roi;
        d.roi_total = roi_seen;
        d.roi_kept  = roi_passed;
        d.run_end   = run_end;
        d.is_last   = is_last;
        owed_q.push_back(d);
    endtask

    // decide the held event against the new one, then hold or flush
    task automatic weigh_event();
        logic [DAY_W-1:0]    day;
        logic [SEC_W-1:0]    sec;
        logic [NANO_W-1:0]   nano;
        logic [NANO_W-1:0]   gap_ns;
        logic [ENERGY_W-1:0] energy;
        logic                fit;
        logic                fin;
        logic                roi;
        logic                pair;
        longint              px;
        longint              py;
        longint              pz;
        longint              r2;
        day    = s_tdata[19:0];
        sec    = s_tdata[36:20];
        nano   = s_tdata[66:37];
        energy = s_tdata[82:67];
        px     = longint'($signed(s_tdata[97:83]));
        py     = longint'($signed(s_tdata[112:98]));
        pz     = longint'($signed(s_tdata[127:113]));
        fit    = s_tuser;
        fin    = s_tlast;
        r2     = px * px + py * py + pz * pz;
        roi    = energy > ROI_E_LOW && energy < ROI_E_HIGH && r2 < longint'(ROI_R2_LIMIT) && fit;

        if (held) begin
            gap_ns = nano > held_nano ? nano - held_nano : held_nano - nano;
            pair = day == held_day && sec == held_sec && gap_ns < window &&
                   held_energy > min_energy && energy > min_energy && held_fit && fit;
            owe_decision(!(veto_next || pair), held_energy, held_roi, 1'b0, !fin);
            veto_next = pair;
        end

        if (fin) begin
            owe_decision(1'b0, energy, roi, 1'b1, 1'b1);
            held      = 1'b0;
            veto_next = 1'b1;
        end else begin
            held        = 1'b1;
            held_day    = day;
            held_sec    = sec;
            held_nano   = nano;
            held_energy = energy;
            held_fit    = fit;
            held_roi    = roi;
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // watch all three channels at each edge
    always @(posedge aclk) begin
        decision_t want;
        if (!aresetn) begin
            min_energy  = '0;
            window      = '0;
            held        = 1'b0;
            held_day    = '0;
            held_sec    = '0;
            held_nano   = '0;
            held_energy = '0;
            held_fit    = 1'b0;
            held_roi    = 1'b0;
            veto_next   = 1'b1;
            roi_seen    = '0;
            roi_passed  = '0;
            mismatches  = 0;
            decided     = 0;
            owed_q.delete();
        end else begin
            // result beat against the oldest owed decision
            if (m_tvalid && m_tready) begin
                if (owed_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: decision beat with nothing owed, expected none, got energy=%0d",
                             $time, m_tdata[15:0]);
                end else begin
                    want = owed_q.pop_front();
                    decided++;
                    check_field("keep", 64'(want.keep), 64'(m_tuser[MU_KEEP]));
                    check_field("decided_energy", 64'(want.energy), 64'(m_tdata[15:0]));
                    check_field("in_roi", 64'(want.in_roi), 64'(m_tuser[MU_ROI]));
                    check_field("roi_total", 64'(want.roi_total), 64'(m_tdata[47:16]));
                    check_field("roi_kept", 64'(want.roi_kept), 64'(m_tdata[79:48]));
                    check_field("run_end", 64'(want.run_end), 64'(m_tlast));
                    check_field("last", 64'(want.is_last), 64'(m_tuser[MU_LAST]));
                end
            end
            // event beat
            if (s_tvalid && s_tready) weigh_event();
            // register write
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_ENERGY: min_energy = cfg_data[ENERGY_W-1:0];
                    CFG_WINDOW:     window = cfg_data[NANO_W-1:0];
                    default: ;
                endcase
            end
        end
        in_flight <= owed_q.size();
    end

endmodule

### sim/tb_coincidence_pair_veto_core.sv
module tb_coincidence_pair_veto_core;
    import cpv_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  s_tlast   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = CFG_MIN_ENERGY;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int in_flight;
    int decided;

    // stimulus knobs and bookkeeping
    bit                  tx_idle_on  = 1'b1;
    bit                  rx_stall_on = 1'b1;
    int                  hold_asked  = 0;
    int                  hold_served = 0;
    int                  events_sent = 0;
    int                  runs_sent   = 0;
    int                  settings    = 0;
    logic [ENERGY_W-1:0] cur_min     = '0;
    logic [NANO_W-1:0]   cur_window  = '0;
    logic [DAY_W-1:0]    last_day    = '0;
    logic [SEC_W-1:0]    last_sec    = '0;
    logic [NANO_W-1:0]   last_nano   = '0;

    always #1 aclk = ~aclk;

    coincidence_pair_veto_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    veto_checker watch (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .in_flight  (in_flight),
        .decided    (decided)
    );

    // offer one event beat, after a random gap when idling is on
    task automatic send_event(input logic [DAY_W-1:0] day, input logic [SEC_W-1:0] sec,
                              input logic [NANO_W-1:0] nano, input logic [ENERGY_W-1:0] energy,
                              input logic fit, input logic [POS_W-1:0] px,
                              input logic [POS_W-1:0] py, input logic [POS_W-1:0] pz,
                              input logic fin);
        int gap;
        gap = tx_idle_on ? int'($urandom_range(0, 11)) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {pz, py, px, energy, nano, sec, day};
        s_tuser  <= fit;
        s_tlast  <= fin;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        last_day  = day;
        last_sec  = sec;
        last_nano = nano;
        events_sent++;
        if (fin) runs_sent++;
    endtask

    // stop offering and wait until every owed decision has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (in_flight != 0);
        // a held event may still be moving through the pipe
        repeat (6) @(posedge aclk);
    endtask

    // write both registers while the block is quiet
    task automatic configure(input logic [ENERGY_W-1:0] min_e, input logic [NANO_W-1:0] win);
        settle();
        cfg_index <= CFG_MIN_ENERGY;
        cfg_data  <= CFG_DATA_W'(min_e);
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_WINDOW;
        cfg_data  <= CFG_DATA_W'(win);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_min    = min_e;
        cur_window = win;
        settings++;
    endtask

    // one run: mostly events chained in time to the previous one, some loose ones
    task automatic send_run();
        int                  len;
        logic [DAY_W-1:0]    day;
        logic [SEC_W-1:0]    sec;
        logic [NANO_W-1:0]   nano;
        logic [ENERGY_W-1:0] energy;
        logic                fit;
        logic [POS_W-1:0]    px;
        logic [POS_W-1:0]    py;
        logic [POS_W-1:0]    pz;
        longint              span;
        longint              t;
        len = int'($urandom_range(1, 12));
        for (int i = 0; i < len; i++) begin
            if (i == 0 || $urandom_range(0, 4) == 0) begin
                day  = DAY_W'($urandom);
                sec  = SEC_W'($urandom);
                nano = NANO_W'($urandom);
                if ($urandom_range(0, 1) != 0) begin
                    sec  = SEC_W'($urandom_range(0, 86399));
                    nano = NANO_W'($urandom_range(0, 999999999));
                end
            end else begin
                day  = last_day;
                sec  = last_sec;
                span = longint'(cur_window) + longint'(cur_window / 4) + 2;
                if (span > 1000000000) span = 1000000000;
                t = longint'($urandom_range(0, 32'(span)));
                t = ($urandom_range(0, 1) != 0) ? longint'(last_nano) - t
                                                : longint'(last_nano) + t;
                if (t < 0 || t > longint'({NANO_W{1'b1}})) t = longint'(last_nano);
                nano = NANO_W'(t);
            end
            case ($urandom_range(0, 3))
                0:       energy = ENERGY_W'($urandom_range(2471, 2639));
                1:       energy = ENERGY_W'($urandom_range(2400, 2700));
                2:       energy = ENERGY_W'($urandom_range(32'(cur_min), 65535));
                default: energy = ENERGY_W'($urandom);
            endcase
            fit = $urandom_range(0, 9) != 0;
            if ($urandom_range(0, 3) != 0) begin
                px = POS_W'($urandom_range(0, 4000) - 2000);
                py = POS_W'($urandom_range(0, 4000) - 2000);
                pz = POS_W'($urandom_range(0, 4000) - 2000);
            end else begin
                px = POS_W'($urandom);
                py = POS_W'($urandom);
                pz = POS_W'($urandom);
            end
            send_event(day, sec, nano, energy, fit, px, py, pz, i == len - 1);
        end
    endtask

    // result side: random stall per beat, plus a long hold when asked
    initial begin
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_served != hold_asked) begin
                gap = 120;
                hold_served++;
            end else begin
                gap = rx_stall_on ? int'($urandom_range(0, 11)) : 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // watchdog
    initial begin
        #2000000;
        $display("%0t: timeout with %0d decisions still owed", $time, in_flight);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int               start;
        logic [ENERGY_W-1:0] min_e;
        logic [NANO_W-1:0]   win;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one-event run with time and energy fields at their top values, positions at their largest magnitudes
        configure(16'd100, 30'd1000);
        send_event(20'hFFFFF, 17'h1FFFF, 30'h3FFFFFFF, 16'hFFFF, 1'b1,
                   15'h4000, 15'h3FFF, 15'h4000, 1'b1);

        // run through pair, window edge, energy floor, fit and roi boundaries
        send_event(20'd5, 17'd10, 30'd1000, 16'd2500, 1'b1, 15'd3499, 15'd0, 15'd0, 1'b0);
        send_event(20'd5, 17'd10, 30'd1999, 16'd2500, 1'b1, 15'd0, 15'd0, 15'd0, 1'b0);
        send_event(20'd5, 17'd10, 30'd2999, 16'd2471, 1'b1, 15'd3500, 15'd0, 15'd0, 1'b0);
        send_event(20'd5, 17'd10, 30'd3000, 16'd100, 1'b1, 15'd0, 15'd0, 15'd0, 1'b0);
        send_event(20'd5, 17'd10, 30'd3001, 16'd2639, 1'b0, 15'd0, 15'd0, 15'd0, 1'b0);
        send_event(20'd5, 17'd10, 30'd3002, 16'd2639, 1'b1,
                   15'(-2020), 15'(-2020), 15'(-2020), 1'b0);
        send_event(20'd5, 17'd10, 30'd3003, 16'd2640, 1'b1, 15'd0, 15'd0, 15'd0, 1'b0);
        send_event(20'd5, 17'd11, 30'd3003, 16'd2470, 1'b1, 15'd0, 15'd0, 15'd0, 1'b0);
        send_event(20'd6, 17'd11, 30'd3003, 16'd0, 1'b1, 15'd0, 15'd0, 15'd0, 1'b0);
        send_event(20'd6, 17'd11, 30'd3004, 16'd2600, 1'b1, 15'd0, 15'd0, 15'd0, 1'b1);

        // widest window, zero energy floor
        configure(16'd0, 30'd1000000000);
        send_event(20'd7, 17'd86399, 30'd0, 16'd1, 1'b1, 15'd0, 15'd0, 15'd0, 1'b0);
        send_event(20'd7, 17'd86399, 30'd999999999, 16'd1, 1'b1, 15'd0, 15'd0, 15'd0, 1'b0);
        send_event(20'd7, 17'd86399, 30'd999999999, 16'd0, 1'b1, 15'd0, 15'd0, 15'd0, 1'b0);
        send_event(20'd7, 17'd86399, 30'd999999999, 16'd1, 1'b1, 15'd0, 15'd0, 15'd0, 1'b1);

        // random phases, one setting each
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin min_e = 16'd0;     win = 30'd0;          end
                1: begin min_e = 16'hFFFF;  win = 30'd1000000000; end
                2: begin min_e = 16'd0;     win = 30'd1000000000; end
                3: begin
                    min_e = ENERGY_W'($urandom_range(0, 3000));
                    win   = NANO_W'($urandom_range(0, 5000));
                end
                4: begin
                    min_e = ENERGY_W'($urandom_range(0, 65535));
                    win   = NANO_W'($urandom_range(0, 1000000000));
                end
                5: begin min_e = 16'd2400;  win = 30'd200;        end
                6: begin
                    min_e = ENERGY_W'($urandom_range(0, 500));
                    win   = NANO_W'($urandom_range(0, 300));
                end
                default: begin
                    min_e = 16'd100;
                    win   = NANO_W'($urandom_range(0, 100000));
                end
            endcase
            configure(min_e, win);
            tx_idle_on  = (p % 3) != 1;
            rx_stall_on = (p % 3) != 2;
            if (p == 5) begin
                tx_idle_on  = 1'b0;
                rx_stall_on = 1'b0;
            end
            // long result hold while events keep coming back to back
            if (p == 3) begin
                tx_idle_on = 1'b0;
                hold_asked++;
            end
            start = events_sent;
            while (events_sent - start < 80) send_run();
        end

        settle();
        repeat (10) @(posedge aclk);
        $display("sent %0d events in %0d runs under %0d register settings",
                 events_sent, runs_sent, settings);
        $display("checked %0d keep decisions, %0d field mismatches", decided, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
design/cpv_pkg.sv
design/coincidence_pair_veto_core.sv
sim/veto_checker.sv
sim/tb_coincidence_pair_veto_core.sv
